FILE: rtl/core/i2cbe_pkg.sv
package i2cbe_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6,
        OP_NONE  = 3'd7
    } op_t;

    localparam logic [3:0] PHASE_IDLE    = 4'd0;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] TPS_RESET     = 8'd5;

    typedef struct packed {
        logic [3:0] phase;
        logic [3:0] bit_count;
        logic [7:0] shift_reg;
        logic [2:0] active_op;
        logic [7:0] slot_count;
        logic       scl_level;
        logic       sda_level;
        logic       ack_flag;
        logic [7:0] rx_data;
    } eng_state_t;

    typedef struct packed {
        logic       rejected;
        logic       slave_ack;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

    localparam eng_state_t STATE_RESET = '{
        phase:      PHASE_IDLE,
        bit_count:  4'd0,
        shift_reg:  8'd0,
        active_op:  3'd0,
        slot_count: 8'd0,
        scl_level:  1'b1,
        sda_level:  1'b1,
        ack_flag:   1'b0,
        rx_data:    8'd0
    };

endpackage

FILE: rtl/core/i2cbe_step.sv
module i2cbe_step (
    input  i2cbe_pkg::eng_state_t state,
    input  logic [2:0]            opcode,
    input  logic [7:0]            data_byte,
    input  logic                  sda_in,
    input  logic [7:0]            ticks_per_slot,
    output i2cbe_pkg::eng_state_t state_next,
    output i2cbe_pkg::result_t    result
);
    import i2cbe_pkg::*;

    logic       busy;
    logic [7:0] slot_len;
    logic [3:0] p;
    logic [3:0] bit_inc;
    logic [7:0] shift_one;
    logic       done;
    logic       rej;
    logic       fin;

    assign busy      = (state.phase != PHASE_IDLE);
    assign slot_len  = (ticks_per_slot == 8'd0) ? 8'd1 : ticks_per_slot;
    assign p         = state.phase - 4'd1;
    assign bit_inc   = state.bit_count + 4'd1;
    assign shift_one = {state.shift_reg[6:0], 1'b0};

    always_comb
    begin
        state_next = state;
        done       = 1'b0;
        rej        = 1'b0;
        fin        = 1'b0;
        if (opcode == OP_TICK)
        begin
            if (busy)
            begin
                if ({1'b0, state.slot_count} + 9'd1 >= {1'b0, slot_len})
                begin
                    state_next.slot_count = 8'd0;
                    case (state.active_op)
                        OP_START:
                        begin
                            if (p == 4'd0)
                            begin
                                state_next.sda_level = 1'b0;
                                state_next.phase     = 4'd2;
                            end
                            else
                            begin
                                state_next.scl_level = 1'b0;
                                fin = 1'b1;
                            end
                        end
                        OP_STOP:
                        begin
                            if (p == 4'd0)
                            begin
                                state_next.sda_level = 1'b1;
                                state_next.phase     = 4'd2;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (p == 4'd0)
                            begin
                                state_next.scl_level = 1'b1;
                                state_next.phase     = 4'd2;
                            end
                            else if (p == 4'd1)
                            begin
                                state_next.scl_level = 1'b0;
                                state_next.bit_count = bit_inc;
                                state_next.shift_reg = shift_one;
                                if (bit_inc < BITS_PER_BYTE)
                                begin
                                    state_next.sda_level = shift_one[7];
                                    state_next.phase     = 4'd1;
                                end
                                else
                                begin
                                    state_next.sda_level = 1'b1;
                                    state_next.phase     = 4'd3;
                                end
                            end
                            else if (p == 4'd2)
                            begin
                                state_next.scl_level = 1'b1;
                                state_next.phase     = 4'd4;
                            end
                            else if (p == 4'd3)
                            begin
                                state_next.ack_flag  = ~sda_in;
                                state_next.scl_level = 1'b0;
                                state_next.phase     = 4'd5;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (p == 4'd0)
                            begin
                                state_next.scl_level = 1'b1;
                                state_next.phase     = 4'd2;
                            end
                            else if (p == 4'd1)
                            begin
                                state_next.shift_reg = {state.shift_reg[6:0], sda_in};
                                state_next.bit_count = bit_inc;
                                state_next.scl_level = 1'b0;
                                state_next.phase     = (bit_inc < BITS_PER_BYTE) ? 4'd1 : 4'd3;
                            end
                            else
                            begin
                                state_next.rx_data = state.shift_reg;
                                fin = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (p == 4'd0)
                            begin
                                state_next.scl_level = 1'b1;
                                state_next.phase     = 4'd2;
                            end
                            else if (p == 4'd1)
                            begin
                                state_next.scl_level = 1'b0;
                                state_next.phase     = 4'd3;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                    endcase
                    if (fin)
                    begin
                        state_next.phase = PHASE_IDLE;
                        done = 1'b1;
                    end
                end
                else
                begin
                    state_next.slot_count = state.slot_count + 8'd1;
                end
            end
        end
        else if (opcode != OP_NONE)
        begin
            if (busy)
            begin
                rej = 1'b1;
            end
            else
            begin
                state_next.active_op  = opcode;
                state_next.phase      = 4'd1;
                state_next.slot_count = 8'd0;
                state_next.bit_count  = 4'd0;
                case (opcode)
                    OP_START:
                    begin
                        state_next.sda_level = 1'b1;
                        state_next.scl_level = 1'b1;
                    end
                    OP_STOP:
                    begin
                        state_next.sda_level = 1'b0;
                        state_next.scl_level = 1'b1;
                    end
                    OP_WRITE:
                    begin
                        state_next.shift_reg = data_byte;
                        state_next.sda_level = data_byte[7];
                    end
                    OP_READ:
                    begin
                        state_next.shift_reg = 8'd0;
                        state_next.sda_level = 1'b1;
                        state_next.scl_level = 1'b0;
                    end
                    OP_ACK:
                    begin
                        state_next.sda_level = 1'b0;
                    end
                    default:
                    begin
                        state_next.sda_level = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.scl_out   = state_next.scl_level;
        result.sda_out   = state_next.sda_level;
        result.busy_res  = (state_next.phase != PHASE_IDLE);
        result.done_res  = done;
        result.rx_byte   = state_next.rx_data;
        result.slave_ack = state_next.ack_flag;
        result.rejected  = rej;
    end

endmodule

FILE: rtl/core/i2c_master_byte_engine.sv
// I2C master byte engine.
// Items arrive on the s_ stream: tuser carries the opcode (tick, start, stop,
// write, read, ack, nack) and tdata carries the byte to send and the sampled
// SDA level. Every accepted item gives exactly one result on the m_ stream,
// holding the SCL and SDA drive levels, busy, done, the last received byte,
// the slave acknowledge and the rejected flag.
// A result appears in the cycle after its item is accepted; one item is taken
// per cycle through the single registered step pass while s_tready is high.
// The result register lets a new item in while the previous result is being
// taken; s_tready falls only while a result waits and m_tready is low, so a
// stalled receiver holds the input side back without losing anything.
// The slot length is written on the cfg_ channel, which is always ready; a
// value of zero acts as one. It should be written only while the engine idles.
// Reset releases both lines, empties the result register, returns the
// sequencer to idle and sets the slot length to five ticks.
module i2c_master_byte_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], sda_in[8], zero fill
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_out, sda_out, busy_res, done_res,
                                   // rx_byte[11:4], slave_ack, rejected, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import i2cbe_pkg::*;

    eng_state_t state_reg;
    eng_state_t state_next;
    result_t    result_next;
    result_t    result_reg;
    logic       out_valid_reg;
    logic [7:0] tps_reg;
    logic       in_accept;

    assign s_tready  = ~out_valid_reg | m_tready;
    assign in_accept = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, result_reg};

    i2cbe_step u_step (
        .state          (state_reg),
        .opcode         (s_tuser),
        .data_byte      (s_tdata[7:0]),
        .sda_in         (s_tdata[8]),
        .ticks_per_slot (tps_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
            tps_reg       <= TPS_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                tps_reg <= cfg_data;
            end
            if (in_accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbe_pkg::*;

    typedef struct packed {
        op_t        opcode;
        logic [7:0] data_byte;
        logic       sda_in;
    } bus_item_t;

    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    bus_item_t   item_q[$];
    result_t     line_result_q[$];
    bus_item_t   on_bus;
    bit          offering = 1'b0;

    eng_state_t  eng = STATE_RESET;
    logic [7:0]  slot_len = TPS_RESET;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;
    bit          hold_used = 1'b0;
    int          results_seen = 0;
    int          errors = 0;

    i2c_master_byte_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("i2c_master_byte_engine regression: fail");
        $finish;
    end

    // Advances the engine by one accepted item and returns the line levels and
    // flags that the block should report for it.
    function automatic result_t step_line_engine(input bus_item_t it);
        result_t    r;
        logic [7:0] len;
        logic [2:0] p;
        logic       done;
        logic       rej;
        done = 1'b0;
        rej = 1'b0;
        if (it.opcode == OP_TICK)
        begin
            if (eng.phase != PHASE_IDLE)
            begin
                len = (slot_len == 8'd0) ? 8'd1 : slot_len;
                if ({1'b0, eng.slot_count} + 9'd1 >= {1'b0, len})
                begin
                    eng.slot_count = 8'd0;
                    p = 3'(eng.phase - 4'd1);
                    case (op_t'(eng.active_op))
                        OP_START:
                        begin
                            if (p == 3'd0)
                            begin
                                eng.sda_level = 1'b0;
                                eng.phase = 4'd2;
                            end
                            else
                            begin
                                eng.scl_level = 1'b0;
                                done = 1'b1;
                            end
                        end
                        OP_STOP:
                        begin
                            if (p == 3'd0)
                            begin
                                eng.sda_level = 1'b1;
                                eng.phase = 4'd2;
                            end
                            else
                                done = 1'b1;
                        end
                        OP_WRITE:
                        begin
                            case (p)
                                3'd0:
                                begin
                                    eng.scl_level = 1'b1;
                                    eng.phase = 4'd2;
                                end
                                3'd1:
                                begin
                                    eng.scl_level = 1'b0;
                                    eng.bit_count = eng.bit_count + 4'd1;
                                    eng.shift_reg = eng.shift_reg << 1;
                                    if (eng.bit_count < BITS_PER_BYTE)
                                    begin
                                        eng.sda_level = eng.shift_reg[7];
                                        eng.phase = 4'd1;
                                    end
                                    else
                                    begin
                                        eng.sda_level = 1'b1;
                                        eng.phase = 4'd3;
                                    end
                                end
                                3'd2:
                                begin
                                    eng.scl_level = 1'b1;
                                    eng.phase = 4'd4;
                                end
                                3'd3:
                                begin
                                    eng.ack_flag = ~it.sda_in;
                                    eng.scl_level = 1'b0;
                                    eng.phase = 4'd5;
                                end
                                default:
                                    done = 1'b1;
                            endcase
                        end
                        OP_READ:
                        begin
                            case (p)
                                3'd0:
                                begin
                                    eng.scl_level = 1'b1;
                                    eng.phase = 4'd2;
                                end
                                3'd1:
                                begin
                                    eng.shift_reg = {eng.shift_reg[6:0], it.sda_in};
                                    eng.bit_count = eng.bit_count + 4'd1;
                                    eng.scl_level = 1'b0;
                                    eng.phase = (eng.bit_count < BITS_PER_BYTE) ? 4'd1 : 4'd3;
                                end
                                default:
                                begin
                                    eng.rx_data = eng.shift_reg;
                                    done = 1'b1;
                                end
                            endcase
                        end
                        default:
                        begin
                            case (p)
                                3'd0:
                                begin
                                    eng.scl_level = 1'b1;
                                    eng.phase = 4'd2;
                                end
                                3'd1:
                                begin
                                    eng.scl_level = 1'b0;
                                    eng.phase = 4'd3;
                                end
                                default:
                                    done = 1'b1;
                            endcase
                        end
                    endcase
                    if (done)
                        eng.phase = PHASE_IDLE;
                end
                else
                    eng.slot_count = eng.slot_count + 8'd1;
            end
        end
        else if (it.opcode != OP_NONE)
        begin
            if (eng.phase != PHASE_IDLE)
                rej = 1'b1;
            else
            begin
                eng.active_op = it.opcode;
                eng.phase = 4'd1;
                eng.slot_count = 8'd0;
                eng.bit_count = 4'd0;
                case (it.opcode)
                    OP_START:
                    begin
                        eng.sda_level = 1'b1;
                        eng.scl_level = 1'b1;
                    end
                    OP_STOP:
                    begin
                        eng.sda_level = 1'b0;
                        eng.scl_level = 1'b1;
                    end
                    OP_WRITE:
                    begin
                        eng.shift_reg = it.data_byte;
                        eng.sda_level = it.data_byte[7];
                    end
                    OP_READ:
                    begin
                        eng.shift_reg = 8'd0;
                        eng.sda_level = 1'b1;
                        eng.scl_level = 1'b0;
                    end
                    OP_ACK:
                        eng.sda_level = 1'b0;
                    default:
                        eng.sda_level = 1'b1;
                endcase
            end
        end
        r.scl_out = eng.scl_level;
        r.sda_out = eng.sda_level;
        r.busy_res = (eng.phase != PHASE_IDLE);
        r.done_res = done;
        r.rx_byte = eng.rx_data;
        r.slave_ack = eng.ack_flag;
        r.rejected = rej;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch in %s on result %0d: got %0h, expected %0h",
                 field, results_seen, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                line_result_q.push_back(step_line_engine(on_bus));
                offering = 1'b0;
            end
            if (!s_tvalid || s_tready)
            begin
                if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = item_q.pop_front();
                    offering = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, on_bus.sda_in, on_bus.data_byte};
                    s_tuser <= on_bus.opcode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[13:0]);
                results_seen++;
                if (line_result_q.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 0);
                else
                begin
                    want = line_result_q.pop_front();
                    if (got.scl_out !== want.scl_out)
                        report_mismatch("scl_out", got.scl_out, want.scl_out);
                    if (got.sda_out !== want.sda_out)
                        report_mismatch("sda_out", got.sda_out, want.sda_out);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
                    if (got.slave_ack !== want.slave_ack)
                        report_mismatch("slave_ack", got.slave_ack, want.slave_ack);
                    if (got.rejected !== want.rejected)
                        report_mismatch("rejected", got.rejected, want.rejected);
                    if (m_tdata[15:14] !== 2'b00)
                        report_mismatch("zero fill", m_tdata[15:14], 0);
                end
            end
            // A long hold-off lets the result register fill and stall the input side.
            if (!hold_used && results_seen >= HOLD_AT)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_item(input op_t op, input logic [7:0] d, input logic lvl);
        bus_item_t it;
        it.opcode = op;
        it.data_byte = d;
        it.sda_in = lvl;
        item_q.push_back(it);
    endtask

    task automatic push_ticks(input int n, input bit rand_sda, input logic lvl);
        repeat (n)
            push_item(OP_TICK, 8'($urandom), rand_sda ? 1'($urandom) : lvl);
    endtask

    // Issues one command followed by roughly the ticks it needs; now and then
    // the ticks fall short so that the next command finds the engine busy.
    task automatic issue(input op_t op, input logic [7:0] d);
        int slots;
        int n;
        case (op)
            OP_WRITE: slots = 19;
            OP_READ:  slots = 17;
            OP_ACK,
            OP_NACK:  slots = 3;
            default:  slots = 2;
        endcase
        push_item(op, d, 1'($urandom));
        n = slots * ((slot_len == 8'd0) ? 1 : int'(slot_len));
        case ($urandom_range(9))
            0:       n = $urandom_range(n);
            1:       n = n + $urandom_range(6);
            default: ;
        endcase
        push_ticks(n, 1'b1, 1'b0);
    endtask

    task automatic add_transfers(input int target);
        int goal;
        int nbytes;
        goal = item_q.size() + target;
        while (item_q.size() < goal)
        begin
            if ($urandom_range(7) == 0)
                push_item(op_t'($urandom_range(7)), 8'($urandom), 1'($urandom));
            issue(OP_START, 8'($urandom));
            nbytes = $urandom_range(1, 3);
            for (int i = 0; i < nbytes; i++)
            begin
                if ($urandom_range(1) == 0)
                    issue(OP_WRITE, 8'($urandom));
                else
                begin
                    issue(OP_READ, 8'($urandom));
                    issue((i == nbytes - 1) ? OP_NACK : OP_ACK, 8'($urandom));
                end
            end
            issue(OP_STOP, 8'($urandom));
        end
    endtask

    // Waits until every item is taken and every result checked, then ticks
    // the engine back to idle so that the slot length can be changed safely.
    task automatic settle();
        do
        begin
            while (item_q.size() != 0 || offering || line_result_q.size() != 0)
                @(posedge clk);
            if (eng.phase != PHASE_IDLE)
                push_ticks(1, 1'b1, 1'b0);
        end
        while (eng.phase != PHASE_IDLE || item_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slot_len(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        slot_len = v;
    endtask

    initial
    begin
        send_idle_pct = 17;
        recv_idle_pct = 52;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset slot length: idle tick, the unused opcode, a start and a
        // command that arrives while the start is still running.
        push_item(OP_TICK, 8'hFF, 1'b1);
        push_item(OP_NONE, 8'hA5, 1'b0);
        push_item(OP_START, 8'h00, 1'b0);
        push_item(OP_READ, 8'h5A, 1'b1);
        push_ticks(10, 1'b1, 1'b0);
        settle();

        // A slot length of zero behaves as one tick per slot.
        write_slot_len(8'd0);
        push_item(OP_STOP, 8'h00, 1'b0);
        push_ticks(2, 1'b1, 1'b0);
        push_item(OP_ACK, 8'h00, 1'b0);
        push_ticks(3, 1'b1, 1'b0);
        push_item(OP_NACK, 8'hFF, 1'b1);
        push_ticks(3, 1'b1, 1'b0);
        push_item(OP_WRITE, 8'hFF, 1'b0);
        push_ticks(19, 1'b0, 1'b0);
        push_item(OP_WRITE, 8'h00, 1'b1);
        push_ticks(19, 1'b0, 1'b1);
        push_item(OP_READ, 8'h00, 1'b0);
        push_ticks(17, 1'b0, 1'b1);
        push_item(OP_READ, 8'hFF, 1'b1);
        push_ticks(17, 1'b0, 1'b0);
        settle();

        write_slot_len(8'd1);
        add_transfers(100);
        settle();

        send_idle_pct = 52;
        recv_idle_pct = 17;
        write_slot_len(8'd2);
        add_transfers(60);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_slot_len(8'd10);
        issue(OP_START, 8'($urandom));
        issue(OP_STOP, 8'($urandom));
        settle();

        write_slot_len(8'($urandom_range(1, 4)));
        add_transfers(30);
        settle();

        if (errors == 0)
            $display("i2c_master_byte_engine regression: pass");
        else
            $display("i2c_master_byte_engine regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/i2cbe_pkg.sv
rtl/core/i2cbe_step.sv
rtl/core/i2c_master_byte_engine.sv
verif/tb_top.sv
